### hw/rtl/ivpa_pkg.sv
// ----------------------------------------------------------------------------
// ivpa_pkg
// Shared types and constants of the interrupt vector pool allocator: word
// geometry of the occupancy map, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ivpa_pkg;

    localparam int VEC_W  = 8;              // vector number width
    localparam int WORD_W = 32;             // occupancy bits scanned per cycle
    localparam int BIT_W  = 5;              // bit index within one word
    localparam int WIDX_W = VEC_W - BIT_W;  // word index within the 256-vector space

    localparam logic [VEC_W-1:0] FIRST_USABLE_RESET = 8'd48;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC,
        S_FREE
    } t_state;

    typedef struct packed {
        logic start;       // latch the request, load the word pointer
        logic advance;     // step the word pointer
        logic clear_word;  // clear the in-range bits of the current word
        logic commit;      // finish: update map on allocate, load the result beat
    } t_dp_cmd;

    typedef struct packed {
        logic found;       // current word holds a free in-window vector
        logic last_word;   // pointer sits on the last word of the pool
    } t_dp_sts;

endpackage

### hw/rtl/ivpa_datapath.sv
// ----------------------------------------------------------------------------
// ivpa_datapath
// Occupancy map, first-usable register, word pointer, per-word first-fit
// search and range-clear masks, and the result registers.
// ----------------------------------------------------------------------------
module ivpa_datapath #(
    parameter int VECTOR_COUNT = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ivpa_pkg::t_dp_cmd       i_cmd,
    output ivpa_pkg::t_dp_sts       o_sts,
    input  logic                    i_func,
    input  logic [7:0]              i_free_base,
    input  logic [7:0]              i_free_count,
    input  logic                    i_cfg_valid,
    input  logic [7:0]              i_cfg_data,
    output logic [7:0]              o_granted_vector,
    output logic                    o_alloc_failed
);
    import ivpa_pkg::*;

    localparam int WORDS = (VECTOR_COUNT + WORD_W - 1) / WORD_W;
    localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int DEPTH = 2 ** WW;
    localparam logic [WW-1:0]     LAST_WORD = WW'(WORDS - 1);
    localparam logic [WIDX_W-1:0] LAST_WIDX = WIDX_W'(WORDS - 1);
    localparam logic [VEC_W:0]    VC_LIMIT  = (VEC_W + 1)'(VECTOR_COUNT);

    t_word              r_map [DEPTH];
    logic [WW-1:0]      r_word;
    logic               r_func;
    logic [VEC_W-1:0]   r_base;
    logic [VEC_W-1:0]   r_count;
    logic [VEC_W-1:0]   r_first;
    logic [VEC_W-1:0]   r_granted;
    logic               r_failed;

    t_word              w_cur;
    t_word              w_win;
    t_word              w_rng;
    t_word              w_avail;
    t_word              w_onehot;
    logic               w_found;
    logic [BIT_W-1:0]   w_bit;
    logic [WIDX_W-1:0]  w_first_word;
    logic [WW-1:0]      w_start;
    logic [VEC_W-1:0]   w_grant_vec;

    assign w_cur = r_map[r_word];

    // Window and free-range masks for every bit of the current word.
    always_comb begin
        logic [VEC_W-1:0] v;
        logic [VEC_W-1:0] off;
        w_win = '0;
        w_rng = '0;
        for (int b = 0; b < WORD_W; b++) begin
            v        = {WIDX_W'(r_word), BIT_W'(b)};
            off      = v - r_base;
            w_win[b] = (v >= r_first) && ({1'b0, v} < VC_LIMIT);
            w_rng[b] = off < r_count;
        end
    end

    // Lowest free vector of the word.
    assign w_avail = ~w_cur & w_win;
    assign w_found = |w_avail;

    always_comb begin
        w_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (w_avail[b]) begin
                w_bit = BIT_W'(b);
            end
        end
    end

    assign w_onehot    = t_word'(1) << w_bit;
    assign w_grant_vec = {WIDX_W'(r_word), w_bit};

    // Scan starts at the word of the first usable vector, clamped to the pool.
    assign w_first_word = r_first[VEC_W-1 -: WIDX_W];
    assign w_start      = (w_first_word > LAST_WIDX) ? LAST_WORD : w_first_word[WW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= FIRST_USABLE_RESET;
            for (int w = 0; w < DEPTH; w++) begin
                r_map[w] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_first <= i_cfg_data;
            end
            if (i_cmd.commit && !r_func && w_found) begin
                r_map[r_word] <= w_cur | w_onehot;
            end else if (i_cmd.clear_word) begin
                r_map[r_word] <= w_cur & ~(w_rng & w_win);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_func  <= i_func;
            r_base  <= i_free_base;
            r_count <= i_free_count;
            r_word  <= i_func ? '0 : w_start;
        end else if (i_cmd.advance) begin
            r_word  <= r_word + WW'(1);
        end
        if (i_cmd.commit) begin
            r_granted <= (!r_func && w_found) ? w_grant_vec : '0;
            r_failed  <= !r_func && !w_found;
        end
    end

    assign o_sts.found      = w_found;
    assign o_sts.last_word  = (r_word >= LAST_WORD);
    assign o_granted_vector = r_granted;
    assign o_alloc_failed   = r_failed;

    // An allocate fails only once the scan has reached the end of the pool.
    a_fail_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !r_func && !w_found) |-> (r_word >= LAST_WORD))
        else $error("allocate failed before scanning the whole pool");

    // A free request always answers vector 0 without the fail flag.
    a_free_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_func) |=> (r_granted == '0 && !r_failed))
        else $error("free request returned a nonzero result");

    // A granted vector is marked in use right after the commit.
    a_grant_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !r_func && w_found) |=> (r_map[$past(r_word)][$past(w_bit)]))
        else $error("granted vector not marked in use");

endmodule

### hw/rtl/ivpa_ctrl.sv
// ----------------------------------------------------------------------------
// ivpa_ctrl
// Request sequencer: accepts a request, walks the occupancy map word by word
// and commits the result beat when the output register is free.
// ----------------------------------------------------------------------------
module ivpa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_func,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ivpa_pkg::t_dp_cmd   o_cmd,
    input  ivpa_pkg::t_dp_sts   i_sts
);
    import ivpa_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;
    logic   w_in_accept;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_func ? S_FREE : S_ALLOC;
                end
            end
            S_ALLOC: begin
                if ((i_sts.found || i_sts.last_word) && w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_FREE: begin
                if (i_sts.last_word && w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.start = i_in_valid;
            end
            S_ALLOC: begin
                if (i_sts.found || i_sts.last_word) begin
                    o_cmd.commit = w_out_free;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_FREE: begin
                o_cmd.clear_word = 1'b1;
                if (i_sts.last_word) begin
                    o_cmd.commit = w_out_free;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    assign n_out_valid = o_cmd.commit || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // Never overwrite a result beat that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> w_out_free)
        else $error("result committed over a stalled beat");

    // An accepted request always starts a walk.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_state == S_ALLOC || r_state == S_FREE))
        else $error("accepted request did not start");

    // A new result beat appears only after a commit.
    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.commit))
        else $error("output valid without a commit");

endmodule

### hw/rtl/interrupt_vector_pool_allocator.sv
// ----------------------------------------------------------------------------
// interrupt_vector_pool_allocator
// First-fit allocator over a one-bit-per-vector occupancy map.
// ----------------------------------------------------------------------------
// A request with func 0 allocates the lowest free vector at or above the
// first usable vector register and below VECTOR_COUNT, marks it in use and
// returns it; if none is free it returns 0 with alloc_failed set. A request
// with func 1 frees free_count vectors from free_base up, the vector number
// wrapping modulo 256, and skips any vector outside the usable window; it
// always returns 0 with alloc_failed clear. Every request gives one result
// beat. When the register is 0, vector 0 can be granted and comes back as 0
// with alloc_failed clear. Writing the register leaves the map untouched.
// Timing: the map is held as 32-bit words and one word is examined per
// cycle. An allocate is accepted and then scans word by word from the word
// of the first usable vector up to the first word with a free vector or
// the last word; a free is accepted and then clears every word of the pool.
// The next request is taken as soon as the result is in the output
// register; a result waits there while the output stalls, and a request
// that finishes meanwhile holds until the register is free.
// The map resets to all free; no clearing pass is needed.
// Configuration writes are always taken and must only be issued while idle.
// ----------------------------------------------------------------------------
module interrupt_vector_pool_allocator #(
    parameter int VECTOR_COUNT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [7:0]  i_free_base,
    input  logic [7:0]  i_free_count,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_granted_vector,
    output logic        o_alloc_failed,
    // first usable vector register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    import ivpa_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Register writes never wait.
    assign o_cfg_ready = 1'b1;

    // Sequencer: accept, walk the map, commit into the output register.
    ivpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // Map, register, search and clear logic, result registers.
    ivpa_datapath #(
        .VECTOR_COUNT (VECTOR_COUNT)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_func           (i_func),
        .i_free_base      (i_free_base),
        .i_free_count     (i_free_count),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .o_granted_vector (o_granted_vector),
        .o_alloc_failed   (o_alloc_failed)
    );

endmodule
